/* design/smx_pkg.sv */
// ----------------------------------------------------------------------------
// smx_pkg
// Shared types and codes of the stack machine execute unit.
// ----------------------------------------------------------------------------
package smx_pkg;

   localparam int DATA_W  = 32;
   localparam int TYPE_W  = 4;
   localparam int FAULT_W = 2;
   localparam int NPC_W   = 10;

   typedef enum logic [TYPE_W-1:0] {
      OP_READ  = 4'd0,
      OP_WRITE = 4'd1,
      OP_DUP   = 4'd2,
      OP_MUL   = 4'd3,
      OP_ADD   = 4'd4,
      OP_SUB   = 4'd5,
      OP_GT    = 4'd6,
      OP_LT    = 4'd7,
      OP_EQ    = 4'd8,
      OP_JMPZ  = 4'd9,
      OP_PUSH  = 4'd10,
      OP_POP   = 4'd11,
      OP_ROT   = 4'd12
   } op_type;

   typedef enum logic [FAULT_W-1:0] {
      FAULT_NONE      = 2'd0,
      FAULT_UNDERFLOW = 2'd1,
      FAULT_OVERFLOW  = 2'd2,
      FAULT_BAD_COUNT = 2'd3
   } fault_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_PUSH,
      CELL_POP,
      CELL_REPLACE,
      CELL_ROT
   } cell_op_type;

   typedef struct packed {
      cell_op_type        op;
      logic [DATA_W-1:0]  value;
   } cell_cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_POP,
      ST_MOD,
      ST_QUOT,
      ST_REM
   } state_type;

endpackage

/* design/smx_cell.sv */
// ----------------------------------------------------------------------------
// smx_cell
// One stack entry; shifts toward or away from the top on command.
// ----------------------------------------------------------------------------
module smx_cell #(
   parameter int INDEX = 0,
   parameter int POS_W = 9
) (
   input  logic                        clock,
   input  smx_pkg::cell_cmd_type       cmd,
   input  logic [POS_W-1:0]            rot_last,
   input  logic [smx_pkg::DATA_W-1:0]  prev_data,
   input  logic [smx_pkg::DATA_W-1:0]  next_data,
   input  logic [smx_pkg::DATA_W-1:0]  top_data,
   output logic [smx_pkg::DATA_W-1:0]  data
);

   logic [smx_pkg::DATA_W-1:0] data_ff;
   logic [smx_pkg::DATA_W-1:0] data_in;
   logic [POS_W-1:0]           pos;

   assign pos = POS_W'(INDEX);

   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         smx_pkg::CELL_PUSH: begin
            data_in = (INDEX == 0) ? cmd.value : prev_data;
         end
         smx_pkg::CELL_POP: begin
            data_in = next_data;
         end
         smx_pkg::CELL_REPLACE: begin
            data_in = (INDEX == 0) ? cmd.value : next_data;
         end
         smx_pkg::CELL_ROT: begin
            if (pos < rot_last) begin
               data_in = next_data;
            end else if (pos == rot_last) begin
               data_in = top_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

/* design/stack_machine_execute.sv */
// ----------------------------------------------------------------------------
// stack_machine_execute
// Executes one stack machine instruction per transaction on a 32-bit stack.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one instruction (opcode, immediate, read data);
//   rsp_ channel returns one transaction per instruction: write value,
//   next program counter and fault code.
//   The stack is a row of shift cells, top of stack in the first cell, so
//   every operand is at a fixed place and a push or pop moves all entries
//   by one place at once.
//   Most instructions have their result registered in the cycle after
//   acceptance. JMPZ and POP n (n above one) shift in ST_POP (one shift per
//   cycle); a taken jump with a PROGRAM_DEPTH that is not a power of two
//   then reduces the address by reciprocal multiplication in ST_MOD,
//   ST_QUOT and ST_REM. Throughput: one instruction per cycle for
//   single-shift instructions while the receiver keeps up; req_stall is high
//   outside ST_IDLE or while a result waits on a stalled receiver.
//   Reset empties the stack and clears the program counter; stack contents
//   are undefined until written. A faulting instruction leaves the state
//   unchanged.
// ----------------------------------------------------------------------------
module stack_machine_execute #(
   parameter int STACK_DEPTH   = 256,
   parameter int PROGRAM_DEPTH = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [smx_pkg::TYPE_W-1:0]          req_type,
   input  logic signed [smx_pkg::DATA_W-1:0]   req_immediate,
   input  logic signed [smx_pkg::DATA_W-1:0]   req_read_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_write_valid,
   output logic signed [smx_pkg::DATA_W-1:0]   rsp_write_data,
   output logic [smx_pkg::NPC_W-1:0]           rsp_next_pc,
   output logic [smx_pkg::FAULT_W-1:0]         rsp_fault
);

   localparam int SP_W = $clog2(STACK_DEPTH + 1);
   localparam int PC_W = (PROGRAM_DEPTH > 2) ? $clog2(PROGRAM_DEPTH) : 1;
   localparam bit PD_POW2 = ((PROGRAM_DEPTH & (PROGRAM_DEPTH - 1)) == 0);
   localparam int DW = smx_pkg::DATA_W;
   localparam logic [DW-1:0] RECIP = DW'((64'd1 << DW) / 64'(PROGRAM_DEPTH));

   smx_pkg::state_type    state_ff, state_in;
   logic [SP_W-1:0]       sp_ff, sp_in;
   logic [PC_W-1:0]       pc_ff, pc_in;
   logic [SP_W-1:0]       cnt_ff, cnt_in;
   logic                  mod_ff, mod_in;
   logic [2*DW-1:0]       prod_ff, prod_in;
   logic [DW-1:0]         qp_ff, qp_in;
   logic [DW-1:0]         jaddr_ff, jaddr_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_wv_ff, rsp_wv_in;
   logic [DW-1:0]         rsp_wd_ff, rsp_wd_in;
   logic [PC_W-1:0]       rsp_pc_ff, rsp_pc_in;
   smx_pkg::fault_type    rsp_fault_ff, rsp_fault_in;

   smx_pkg::cell_cmd_type cmd;
   logic [SP_W-1:0]       rot_last;
   logic [DW-1:0]         cell_data [STACK_DEPTH];

   logic                  accept;
   logic [DW-1:0]         imm, rd, top, second, alu;
   logic [DW-1:0]         need;
   logic                  grow;
   smx_pkg::fault_type    fault;
   smx_pkg::op_type       op;
   logic [PC_W-1:0]       pc_inc;
   logic [DW-1:0]         rem_diff, rem_fix;

   assign req_stall = (state_ff != smx_pkg::ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign op     = smx_pkg::op_type'(req_type);
   assign imm    = req_immediate;
   assign rd     = req_read_data;
   assign top    = cell_data[0];
   assign second = cell_data[1];
   assign pc_inc = (pc_ff == PC_W'(PROGRAM_DEPTH - 1)) ? '0 : pc_ff + 1'b1;

   // quotient estimate is low by at most one, so one correction step
   assign rem_diff = jaddr_ff - qp_ff;
   assign rem_fix  = (rem_diff >= DW'(PROGRAM_DEPTH)) ? rem_diff - DW'(PROGRAM_DEPTH)
                                                      : rem_diff;

   always_comb begin
      case (op)
         smx_pkg::OP_MUL: alu = top * second;
         smx_pkg::OP_ADD: alu = top + second;
         smx_pkg::OP_SUB: alu = top - second;
         smx_pkg::OP_GT:  alu = {31'b0, $signed(top) > $signed(second)};
         smx_pkg::OP_LT:  alu = {31'b0, $signed(top) < $signed(second)};
         smx_pkg::OP_EQ:  alu = {31'b0, top == second};
         default:         alu = top;
      endcase
   end

   always_comb begin
      need  = '0;
      grow  = 1'b0;
      fault = smx_pkg::FAULT_NONE;
      case (op)
         smx_pkg::OP_READ, smx_pkg::OP_PUSH: grow = 1'b1;
         smx_pkg::OP_WRITE: need = 32'd1;
         smx_pkg::OP_DUP: begin
            need = 32'd1;
            grow = 1'b1;
         end
         smx_pkg::OP_MUL, smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_GT,
         smx_pkg::OP_LT, smx_pkg::OP_EQ, smx_pkg::OP_JMPZ: need = 32'd2;
         smx_pkg::OP_POP: begin
            if (imm[DW-1]) fault = smx_pkg::FAULT_BAD_COUNT;
            else need = imm;
         end
         smx_pkg::OP_ROT: begin
            if (imm[DW-1] || imm == '0) fault = smx_pkg::FAULT_BAD_COUNT;
            else need = imm;
         end
         default: need = '0;
      endcase
      if (fault == smx_pkg::FAULT_NONE && need > DW'(sp_ff)) begin
         fault = smx_pkg::FAULT_UNDERFLOW;
      end
      if (fault == smx_pkg::FAULT_NONE && grow && sp_ff >= SP_W'(STACK_DEPTH)) begin
         fault = smx_pkg::FAULT_OVERFLOW;
      end
   end

   always_comb begin
      state_in     = state_ff;
      sp_in        = sp_ff;
      pc_in        = pc_ff;
      cnt_in       = cnt_ff;
      mod_in       = mod_ff;
      prod_in      = prod_ff;
      qp_in        = qp_ff;
      jaddr_in     = jaddr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_wv_in    = rsp_wv_ff;
      rsp_wd_in    = rsp_wd_ff;
      rsp_pc_in    = rsp_pc_ff;
      rsp_fault_in = rsp_fault_ff;
      cmd.op       = smx_pkg::CELL_HOLD;
      cmd.value    = top;
      rot_last     = '0;
      case (state_ff)
         smx_pkg::ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_wv_in    = 1'b0;
               rsp_wd_in    = '0;
               rsp_fault_in = fault;
               if (fault != smx_pkg::FAULT_NONE) begin
                  rsp_pc_in = pc_ff;
               end else begin
                  rsp_pc_in = pc_inc;
                  pc_in     = pc_inc;
                  case (op)
                     smx_pkg::OP_READ: begin
                        cmd.op    = smx_pkg::CELL_PUSH;
                        cmd.value = rd;
                        sp_in     = sp_ff + 1'b1;
                     end
                     smx_pkg::OP_PUSH: begin
                        cmd.op    = smx_pkg::CELL_PUSH;
                        cmd.value = imm;
                        sp_in     = sp_ff + 1'b1;
                     end
                     smx_pkg::OP_DUP: begin
                        cmd.op    = smx_pkg::CELL_PUSH;
                        cmd.value = top;
                        sp_in     = sp_ff + 1'b1;
                     end
                     smx_pkg::OP_WRITE: begin
                        cmd.op    = smx_pkg::CELL_POP;
                        sp_in     = sp_ff - 1'b1;
                        rsp_wv_in = 1'b1;
                        rsp_wd_in = top;
                     end
                     smx_pkg::OP_MUL, smx_pkg::OP_ADD, smx_pkg::OP_SUB,
                     smx_pkg::OP_GT, smx_pkg::OP_LT, smx_pkg::OP_EQ: begin
                        cmd.op    = smx_pkg::CELL_REPLACE;
                        cmd.value = alu;
                        sp_in     = sp_ff - 1'b1;
                     end
                     smx_pkg::OP_JMPZ: begin
                        cmd.op       = smx_pkg::CELL_POP;
                        sp_in        = sp_ff - SP_W'(2);
                        cnt_in       = SP_W'(1);
                        state_in     = smx_pkg::ST_POP;
                        rsp_valid_in = 1'b0;
                        mod_in       = 1'b0;
                        jaddr_in     = top;
                        if (second == '0) begin
                           if (PD_POW2) begin
                              rsp_pc_in = PC_W'(top);
                              pc_in     = PC_W'(top);
                           end else begin
                              mod_in = 1'b1;
                           end
                        end
                     end
                     smx_pkg::OP_POP: begin
                        if (imm != '0) begin
                           cmd.op = smx_pkg::CELL_POP;
                           sp_in  = sp_ff - SP_W'(imm);
                           if (imm != 32'd1) begin
                              cnt_in       = SP_W'(imm - 32'd1);
                              mod_in       = 1'b0;
                              state_in     = smx_pkg::ST_POP;
                              rsp_valid_in = 1'b0;
                           end
                        end
                     end
                     smx_pkg::OP_ROT: begin
                        cmd.op   = smx_pkg::CELL_ROT;
                        rot_last = SP_W'(imm - 32'd1);
                     end
                     default: begin
                        cmd.op = smx_pkg::CELL_HOLD;
                     end
                  endcase
               end
            end
         end
         smx_pkg::ST_POP: begin
            cmd.op = smx_pkg::CELL_POP;
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == SP_W'(1)) begin
               if (mod_ff) begin
                  state_in = smx_pkg::ST_MOD;
               end else begin
                  state_in     = smx_pkg::ST_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end
         end
         smx_pkg::ST_MOD: begin
            // address times reciprocal of the program depth
            prod_in  = {{DW{1'b0}}, jaddr_ff} * {{DW{1'b0}}, RECIP};
            state_in = smx_pkg::ST_QUOT;
         end
         smx_pkg::ST_QUOT: begin
            qp_in    = prod_ff[2*DW-1:DW] * DW'(PROGRAM_DEPTH);
            state_in = smx_pkg::ST_REM;
         end
         smx_pkg::ST_REM: begin
            state_in     = smx_pkg::ST_IDLE;
            rsp_pc_in    = PC_W'(rem_fix);
            pc_in        = PC_W'(rem_fix);
            rsp_valid_in = 1'b1;
         end
         default: begin
            state_in = smx_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= smx_pkg::ST_IDLE;
         sp_ff        <= '0;
         pc_ff        <= '0;
         cnt_ff       <= '0;
         mod_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sp_ff        <= sp_in;
         pc_ff        <= pc_in;
         cnt_ff       <= cnt_in;
         mod_ff       <= mod_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      qp_ff        <= qp_in;
      jaddr_ff     <= jaddr_in;
      rsp_wv_ff    <= rsp_wv_in;
      rsp_wd_ff    <= rsp_wd_in;
      rsp_pc_ff    <= rsp_pc_in;
      rsp_fault_ff <= rsp_fault_in;
   end

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      smx_cell #(
         .INDEX (i),
         .POS_W (SP_W)
      ) u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .rot_last  (rot_last),
         .prev_data ((i == 0) ? top : cell_data[(i == 0) ? 0 : i - 1]),
         .next_data (cell_data[(i == STACK_DEPTH - 1) ? i : i + 1]),
         .top_data  (top),
         .data      (cell_data[i])
      );
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_write_valid = rsp_wv_ff;
   assign rsp_write_data  = rsp_wd_ff;
   assign rsp_next_pc     = smx_pkg::NPC_W'(rsp_pc_ff);
   assign rsp_fault       = rsp_fault_ff;

endmodule

/* design/smx_checker.sv */
// ----------------------------------------------------------------------------
// smx_checker
// Port-level checks of the stack machine execute unit.
// ----------------------------------------------------------------------------
module smx_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic [smx_pkg::TYPE_W-1:0]          req_type,
   input logic signed [smx_pkg::DATA_W-1:0]   req_immediate,
   input logic signed [smx_pkg::DATA_W-1:0]   req_read_data,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic                                rsp_write_valid,
   input logic signed [smx_pkg::DATA_W-1:0]   rsp_write_data,
   input logic [smx_pkg::NPC_W-1:0]           rsp_next_pc,
   input logic [smx_pkg::FAULT_W-1:0]         rsp_fault
);

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_stall |=> req_valid && $stable(req_type)
         && $stable(req_immediate) && $stable(req_read_data))
      else $error("stalled request transaction changed");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_write_data)
         && $stable(rsp_next_pc) && $stable(rsp_fault) && $stable(rsp_write_valid))
      else $error("stalled transaction changed");

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_fault_no_write: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault != smx_pkg::FAULT_NONE |-> !rsp_write_valid
         && rsp_write_data == '0)
      else $error("faulting transaction carries a write");

   a_write_only_op: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_write_valid |-> rsp_write_data == '0)
      else $error("write data without write valid");

endmodule

bind stack_machine_execute smx_checker u_smx_checker (.*);

/* dv/testbench.sv */
// ----------------------------------------------------------------------------
// stack_machine_execute testbench
// Drives random and directed instructions into the execute unit with random
// idle bursts on both channels. A scoreboard holds its own copy of the stack
// and program counter, predicts every result and checks each response field.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STACK_SIZE = 256;
   localparam int N_RANDOM   = 600;
   localparam int QUIET_TAIL = 150;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct {
      bit                          write_valid;
      logic [smx_pkg::DATA_W-1:0]  write_data;
      logic [smx_pkg::NPC_W-1:0]   next_pc;
      smx_pkg::fault_type          fault;
   } step_result_type;

   class stack_scoreboard_type;
      logic [smx_pkg::DATA_W-1:0] stack_mem [STACK_SIZE];
      int unsigned                depth;
      logic [smx_pkg::NPC_W-1:0]  pc;
      step_result_type            pending [$];
      int                         mismatches;

      function new();
         depth = 0;
         pc = '0;
         mismatches = 0;
      endfunction

      function void note_instruction(logic [smx_pkg::TYPE_W-1:0] code,
                                     logic [smx_pkg::DATA_W-1:0] imm,
                                     logic [smx_pkg::DATA_W-1:0] rd);
         step_result_type            res;
         int unsigned                need;
         int unsigned                base;
         bit                         grow;
         logic [smx_pkg::DATA_W-1:0] a;
         logic [smx_pkg::DATA_W-1:0] b;
         logic [smx_pkg::NPC_W-1:0]  npc;
         need = 0;
         grow = 0;
         res.write_valid = 0;
         res.write_data = '0;
         res.fault = smx_pkg::FAULT_NONE;
         npc = pc + 1'b1;
         case (code)
            smx_pkg::OP_READ, smx_pkg::OP_PUSH: grow = 1;
            smx_pkg::OP_WRITE: need = 1;
            smx_pkg::OP_DUP: begin
               need = 1;
               grow = 1;
            end
            smx_pkg::OP_MUL, smx_pkg::OP_ADD, smx_pkg::OP_SUB, smx_pkg::OP_GT,
            smx_pkg::OP_LT, smx_pkg::OP_EQ, smx_pkg::OP_JMPZ: need = 2;
            smx_pkg::OP_POP: begin
               if (imm[smx_pkg::DATA_W-1]) res.fault = smx_pkg::FAULT_BAD_COUNT;
               else need = imm;
            end
            smx_pkg::OP_ROT: begin
               if (imm[smx_pkg::DATA_W-1] || imm == 0) res.fault = smx_pkg::FAULT_BAD_COUNT;
               else need = imm;
            end
            default: ;
         endcase
         if (res.fault == smx_pkg::FAULT_NONE && need > depth)
            res.fault = smx_pkg::FAULT_UNDERFLOW;
         if (res.fault == smx_pkg::FAULT_NONE && grow && depth >= STACK_SIZE)
            res.fault = smx_pkg::FAULT_OVERFLOW;
         if (res.fault == smx_pkg::FAULT_NONE) begin
            case (code)
               smx_pkg::OP_READ: begin
                  stack_mem[depth] = rd;
                  depth++;
               end
               smx_pkg::OP_PUSH: begin
                  stack_mem[depth] = imm;
                  depth++;
               end
               smx_pkg::OP_WRITE: begin
                  depth--;
                  res.write_valid = 1;
                  res.write_data = stack_mem[depth];
               end
               smx_pkg::OP_DUP: begin
                  stack_mem[depth] = stack_mem[depth-1];
                  depth++;
               end
               smx_pkg::OP_MUL, smx_pkg::OP_ADD, smx_pkg::OP_SUB,
               smx_pkg::OP_GT, smx_pkg::OP_LT, smx_pkg::OP_EQ: begin
                  a = stack_mem[depth-1];
                  b = stack_mem[depth-2];
                  depth--;
                  case (code)
                     smx_pkg::OP_MUL: a = a * b;
                     smx_pkg::OP_ADD: a = a + b;
                     smx_pkg::OP_SUB: a = a - b;
                     smx_pkg::OP_GT:  a = ($signed(a) > $signed(b)) ? 1 : 0;
                     smx_pkg::OP_LT:  a = ($signed(a) < $signed(b)) ? 1 : 0;
                     default: a = (a == b) ? 1 : 0;
                  endcase
                  stack_mem[depth-1] = a;
               end
               smx_pkg::OP_JMPZ: begin
                  a = stack_mem[depth-1];
                  b = stack_mem[depth-2];
                  depth -= 2;
                  if (b == 0) npc = a[smx_pkg::NPC_W-1:0];
               end
               smx_pkg::OP_POP: depth -= need;
               smx_pkg::OP_ROT: begin
                  a = stack_mem[depth-1];
                  base = depth - need;
                  for (int i = depth - 1; i > base; i--) stack_mem[i] = stack_mem[i-1];
                  stack_mem[base] = a;
               end
               default: ;
            endcase
            pc = npc;
         end
         res.next_pc = pc;
         pending = {pending, res};
      endfunction

      function void check_result(bit wv, logic [smx_pkg::DATA_W-1:0] wd,
                                 logic [smx_pkg::NPC_W-1:0] npc,
                                 logic [smx_pkg::FAULT_W-1:0] flt);
         step_result_type e;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response transaction");
            return;
         end
         e = pending.pop_front();
         if (wv !== e.write_valid || wd !== e.write_data || npc !== e.next_pc
             || flt !== e.fault) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch: expected wv=%0d wd=%h pc=%0d fault=%0d,",
                         " got wv=%0d wd=%h pc=%0d fault=%0d"},
                        e.write_valid, e.write_data, e.next_pc, e.fault,
                        wv, wd, npc, flt);
         end
      endfunction
   endclass

   logic                                clock = 0;
   logic                                reset = 1;
   logic                                req_valid = 0;
   logic                                req_stall;
   logic [smx_pkg::TYPE_W-1:0]          req_type = '0;
   logic signed [smx_pkg::DATA_W-1:0]   req_immediate = '0;
   logic signed [smx_pkg::DATA_W-1:0]   req_read_data = '0;
   logic                                rsp_valid;
   logic                                rsp_stall = 0;
   logic                                rsp_write_valid;
   logic signed [smx_pkg::DATA_W-1:0]   rsp_write_data;
   logic [smx_pkg::NPC_W-1:0]           rsp_next_pc;
   logic [smx_pkg::FAULT_W-1:0]         rsp_fault;

   stack_scoreboard_type sb = new();
   bit  quiet = 0;
   int  cycles = 0;
   int  stall_left = 0;

   stack_machine_execute i_dut (
      .clock, .reset, .req_valid, .req_stall, .req_type, .req_immediate, .req_read_data,
      .rsp_valid, .rsp_stall, .rsp_write_valid, .rsp_write_data, .rsp_next_pc, .rsp_fault
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // response side: check accepted transactions and stall in bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_write_valid, rsp_write_data, rsp_next_pc, rsp_fault);
      if (quiet) begin
         rsp_stall <= 0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) == 0) begin
         rsp_stall <= 1;
         stall_left <= $urandom_range(0, 11);
      end else begin
         rsp_stall <= 0;
      end
   end

   task automatic send(logic [smx_pkg::TYPE_W-1:0] code, logic [smx_pkg::DATA_W-1:0] imm,
                       logic [smx_pkg::DATA_W-1:0] rd);
      if (!quiet && $urandom_range(0, 9) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid <= 1;
      req_type <= code;
      req_immediate <= imm;
      req_read_data <= rd;
      do @(posedge clock); while (req_stall);
      sb.note_instruction(code, imm, rd);
   endtask

   task automatic send_random();
      int unsigned                r;
      int unsigned                d;
      logic [smx_pkg::TYPE_W-1:0] code;
      logic [smx_pkg::DATA_W-1:0] imm;
      d = sb.depth;
      code = 4'($urandom_range(0, 15));
      imm = $urandom;
      r = $urandom_range(0, 99);
      if (code == smx_pkg::OP_PUSH && r < 30) imm = $urandom_range(0, 3);
      if (code == smx_pkg::OP_POP || code == smx_pkg::OP_ROT) begin
         if (r < 80) imm = (d < 4) ? $urandom_range(0, d + 1) : $urandom_range(0, 4);
         else if (r < 88) imm = $urandom_range(0, d + 1);
         else if (r < 95) imm = -$urandom_range(0, 3);
      end
      send(code, imm, $urandom);
   endtask

   initial begin
      int n;
      repeat (3) @(posedge clock);
      reset <= 0;
      // directed part
      send(smx_pkg::OP_WRITE, 0, 0);
      send(smx_pkg::OP_PUSH, 32'h7fffffff, 0);
      send(smx_pkg::OP_PUSH, 32'h80000000, 0);
      send(smx_pkg::OP_READ, 0, 32'hffffffff);
      send(smx_pkg::OP_DUP, 0, 0);
      send(smx_pkg::OP_ADD, 0, 0);
      send(smx_pkg::OP_MUL, 0, 0);
      send(smx_pkg::OP_SUB, 0, 0);
      send(smx_pkg::OP_PUSH, 5, 0);
      send(smx_pkg::OP_GT, 0, 0);
      send(smx_pkg::OP_PUSH, -3, 0);
      send(smx_pkg::OP_LT, 0, 0);
      send(smx_pkg::OP_DUP, 0, 0);
      send(smx_pkg::OP_EQ, 0, 0);
      send(smx_pkg::OP_ROT, 3, 0);
      send(smx_pkg::OP_ROT, 1, 0);
      send(smx_pkg::OP_ROT, 0, 0);
      send(smx_pkg::OP_POP, -1, 0);
      send(smx_pkg::OP_POP, 100, 0);
      send(smx_pkg::OP_POP, 0, 0);
      send(smx_pkg::OP_WRITE, 0, 0);
      send(4'd13, 0, 0);
      send(4'd15, 0, 0);
      send(smx_pkg::OP_PUSH, 0, 0);
      send(smx_pkg::OP_PUSH, 32'h3ff, 0);
      send(smx_pkg::OP_JMPZ, 0, 0);
      // fill to overflow, then random traffic with occasional refills
      while (sb.depth < STACK_SIZE)
         send($urandom_range(0, 1) ? smx_pkg::OP_PUSH : smx_pkg::OP_READ,
              $urandom, $urandom);
      send(smx_pkg::OP_DUP, 0, 0);
      send(smx_pkg::OP_PUSH, 1, 0);
      send(smx_pkg::OP_POP, STACK_SIZE, 0);
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == N_RANDOM - QUIET_TAIL) quiet = 1;
         if ($urandom_range(0, 199) == 0) begin
            n = $urandom_range(20, STACK_SIZE);
            while (sb.depth < n) send(smx_pkg::OP_PUSH, $urandom, 0);
         end
         send_random();
      end
      req_valid <= 0;
      quiet = 1;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
